### hdl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types, codes and sizes for the instruction execute unit.
// ----------------------------------------------------------------------------
package bfe_pkg;

    localparam int DATA_DEPTH    = 65536;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int CELL_BITS     = 16;

    localparam int ADDR_BITS = $clog2(DATA_DEPTH);
    localparam int FILL_BITS = $clog2(DATA_DEPTH + 1);
    localparam int PC_BITS   = $clog2(PROGRAM_DEPTH);

    localparam int QUEUE_DEPTH = 2;
    localparam int QIDX_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam int          OFFSET_BITS  = 16;
    localparam logic [15:0] OFFSET_RESET = 16'd300;

    localparam logic [15:0] CODE_END   = 16'd0;
    localparam logic [15:0] CODE_RIGHT = 16'd1;
    localparam logic [15:0] CODE_LEFT  = 16'd2;
    localparam logic [15:0] CODE_INC   = 16'd3;
    localparam logic [15:0] CODE_DEC   = 16'd4;
    localparam logic [15:0] CODE_OUT   = 16'd5;
    localparam logic [15:0] CODE_IN    = 16'd6;
    localparam logic [15:0] CODE_JZ    = 16'd7;
    localparam logic [15:0] CODE_JNZ   = 16'd8;

    typedef enum logic [1:0] {
        ST_RUN   = 2'd0,
        ST_HALT  = 2'd1,
        ST_BADOP = 2'd2,
        ST_PTR   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        OP_END,
        OP_RIGHT,
        OP_LEFT,
        OP_INC,
        OP_DEC,
        OP_OUT,
        OP_IN,
        OP_JZ,
        OP_JNZ,
        OP_BAD
    } t_op;

    typedef struct packed {
        logic [15:0] cmd;
        logic [11:0] jump_target;
        logic [7:0]  in_char;
        logic        in_eof;
    } t_cmd_item;

    typedef struct packed {
        logic [11:0] next_pc;
        logic        out_valid;
        logic [15:0] out_value;
        t_status     status;
    } t_result_item;

    typedef struct packed {
        t_op                  op;
        logic [PC_BITS-1:0]   target;
        logic [CELL_BITS-1:0] in_value;
    } t_dec_item;

endpackage

### hdl/bfe_front.sv
// ----------------------------------------------------------------------------
// bfe_front
// Accepts instruction transactions, removes the opcode offset, classifies the
// opcode and holds decoded instructions in a short queue for the back end.
// ----------------------------------------------------------------------------
module bfe_front
    import bfe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [OFFSET_BITS-1:0] i_cfg_wdata,
    input  logic                   i_push,
    input  t_cmd_item              i_item,
    output logic                   o_full,
    output logic                   o_valid,
    output t_dec_item              o_item,
    input  logic                   i_ready
);

    logic [OFFSET_BITS-1:0] r_offset;
    t_dec_item              r_slot [QUEUE_DEPTH];
    logic [QIDX_BITS-1:0]   r_wr_idx, n_wr_idx;
    logic [QIDX_BITS-1:0]   r_rd_idx, n_rd_idx;
    logic [QCNT_BITS-1:0]   r_count, n_count;

    logic [15:0] op_code;
    t_dec_item   dec;
    logic        push_ok;
    logic        pop_ok;

    always_comb begin
        op_code      = i_item.cmd - r_offset;
        dec.target   = PC_BITS'(i_item.jump_target);
        dec.in_value = i_item.in_eof ? {CELL_BITS{1'b1}} : CELL_BITS'(i_item.in_char);
        case (op_code)
            CODE_END:   dec.op = OP_END;
            CODE_RIGHT: dec.op = OP_RIGHT;
            CODE_LEFT:  dec.op = OP_LEFT;
            CODE_INC:   dec.op = OP_INC;
            CODE_DEC:   dec.op = OP_DEC;
            CODE_OUT:   dec.op = OP_OUT;
            CODE_IN:    dec.op = OP_IN;
            CODE_JZ:    dec.op = OP_JZ;
            CODE_JNZ:   dec.op = OP_JNZ;
            default:    dec.op = OP_BAD;
        endcase
    end

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_idx];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = o_valid && i_ready;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (push_ok) begin
            n_wr_idx = (r_wr_idx == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_idx + QIDX_BITS'(1);
        end
        if (pop_ok) begin
            n_rd_idx = (r_rd_idx == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_idx + QIDX_BITS'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + QCNT_BITS'(1);
            2'b01:   n_count = r_count - QCNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RESET;
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_wdata;
            end
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_idx] <= dec;
        end
    end

endmodule

### hdl/bfe_core.sv
// ----------------------------------------------------------------------------
// bfe_core
// Executes one decoded instruction per cycle while the result queue has room.
// Keeps the current cell and both neighbors in registers, writes a cell back to
// memory as the pointer leaves it and refills the vacated neighbor by one registered read.
// ----------------------------------------------------------------------------
module bfe_core
    import bfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  t_dec_item    i_item,
    output logic         o_ready,
    input  logic         i_res_ready,
    output logic         o_res_push,
    output t_result_item o_res_item
);

    logic [CELL_BITS-1:0] mem [DATA_DEPTH];

    logic [ADDR_BITS-1:0] r_ptr, n_ptr;
    logic [FILL_BITS-1:0] r_fill, n_fill;
    logic [PC_BITS-1:0]   r_pc, n_pc;
    t_status              r_status, n_status;
    logic [CELL_BITS-1:0] r_cur, n_cur;
    logic [CELL_BITS-1:0] r_hi, n_hi;
    logic [CELL_BITS-1:0] r_lo, n_lo;
    logic                 r_hi_pend, n_hi_pend;
    logic                 r_lo_pend, n_lo_pend;
    logic                 r_rd_zero, n_rd_zero;
    logic [CELL_BITS-1:0] r_rdata;

    logic                 fire;
    logic [CELL_BITS-1:0] rd_value;
    logic [CELL_BITS-1:0] e_hi;
    logic [CELL_BITS-1:0] e_lo;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic                 out_valid;
    logic [PC_BITS-1:0]   pc_inc;
    logic [PC_BITS-1:0]   jump_pc;
    logic [FILL_BITS-1:0] fill_after;
    logic [FILL_BITS-1:0] ptr_ext;

    assign fire       = i_valid && i_res_ready;
    assign o_ready    = i_res_ready;
    assign o_res_push = fire;

    assign rd_value   = r_rd_zero ? '0 : r_rdata;
    assign e_hi       = r_hi_pend ? rd_value : r_hi;
    assign e_lo       = r_lo_pend ? rd_value : r_lo;
    assign pc_inc     = r_pc + PC_BITS'(1);
    assign jump_pc    = i_item.target + PC_BITS'(1);
    assign ptr_ext    = FILL_BITS'(r_ptr);
    assign fill_after = (ptr_ext == r_fill) ? r_fill + FILL_BITS'(1) : r_fill;

    always_comb begin
        n_ptr     = r_ptr;
        n_fill    = r_fill;
        n_pc      = r_pc;
        n_status  = r_status;
        n_cur     = r_cur;
        n_hi      = e_hi;
        n_lo      = e_lo;
        n_hi_pend = 1'b0;
        n_lo_pend = 1'b0;
        n_rd_zero = 1'b1;
        rd_addr   = r_ptr;
        wr_en     = 1'b0;
        out_valid = 1'b0;
        if (fire && (r_status == ST_RUN)) begin
            case (i_item.op)
                OP_END: begin
                    n_status = ST_HALT;
                end
                OP_RIGHT: begin
                    if (r_ptr == ADDR_BITS'(DATA_DEPTH - 1)) begin
                        n_status = ST_PTR;
                    end else begin
                        wr_en     = 1'b1;
                        n_fill    = fill_after;
                        n_ptr     = r_ptr + ADDR_BITS'(1);
                        n_lo      = r_cur;
                        n_cur     = e_hi;
                        rd_addr   = r_ptr + ADDR_BITS'(2);
                        n_hi_pend = 1'b1;
                        n_rd_zero = (ptr_ext + FILL_BITS'(2)) >= fill_after;
                        n_pc      = pc_inc;
                    end
                end
                OP_LEFT: begin
                    if (r_ptr == '0) begin
                        n_status = ST_PTR;
                    end else begin
                        wr_en     = 1'b1;
                        n_fill    = fill_after;
                        n_ptr     = r_ptr - ADDR_BITS'(1);
                        n_hi      = r_cur;
                        n_cur     = e_lo;
                        rd_addr   = r_ptr - ADDR_BITS'(2);
                        n_lo_pend = 1'b1;
                        n_rd_zero = (ptr_ext - FILL_BITS'(2)) >= fill_after;
                        n_pc      = pc_inc;
                    end
                end
                OP_INC: begin
                    n_cur = r_cur + CELL_BITS'(1);
                    n_pc  = pc_inc;
                end
                OP_DEC: begin
                    n_cur = r_cur - CELL_BITS'(1);
                    n_pc  = pc_inc;
                end
                OP_OUT: begin
                    out_valid = 1'b1;
                    n_pc      = pc_inc;
                end
                OP_IN: begin
                    n_cur = i_item.in_value;
                    n_pc  = pc_inc;
                end
                OP_JZ: begin
                    n_pc = (r_cur == '0) ? jump_pc : pc_inc;
                end
                OP_JNZ: begin
                    n_pc = (r_cur != '0) ? jump_pc : pc_inc;
                end
                default: begin
                    n_status = ST_BADOP;
                end
            endcase
        end
    end

    always_comb begin
        o_res_item.next_pc   = 12'(n_pc);
        o_res_item.out_valid = out_valid;
        o_res_item.out_value = out_valid ? 16'(r_cur) : 16'd0;
        o_res_item.status    = n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_fill    <= '0;
            r_pc      <= '0;
            r_status  <= ST_RUN;
            r_cur     <= '0;
            r_hi      <= '0;
            r_lo      <= '0;
            r_hi_pend <= 1'b0;
            r_lo_pend <= 1'b0;
            r_rd_zero <= 1'b1;
        end else begin
            r_ptr     <= n_ptr;
            r_fill    <= n_fill;
            r_pc      <= n_pc;
            r_status  <= n_status;
            r_cur     <= n_cur;
            r_hi      <= n_hi;
            r_lo      <= n_lo;
            r_hi_pend <= n_hi_pend;
            r_lo_pend <= n_lo_pend;
            r_rd_zero <= n_rd_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_ptr] <= r_cur;
        end
        r_rdata <= mem[rd_addr];
    end

endmodule

### hdl/bfe_result_queue.sv
// ----------------------------------------------------------------------------
// bfe_result_queue
// Short queue that holds execution results until the consumer takes them.
// ----------------------------------------------------------------------------
module bfe_result_queue
    import bfe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_result_item i_item,
    output logic         o_full,
    output logic         o_empty,
    output t_result_item o_item,
    input  logic         i_pop
);

    t_result_item         r_slot [QUEUE_DEPTH];
    logic [QIDX_BITS-1:0] r_wr_idx, n_wr_idx;
    logic [QIDX_BITS-1:0] r_rd_idx, n_rd_idx;
    logic [QCNT_BITS-1:0] r_count, n_count;

    logic push_ok;
    logic pop_ok;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slot[r_rd_idx];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        if (push_ok) begin
            n_wr_idx = (r_wr_idx == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_wr_idx + QIDX_BITS'(1);
        end
        if (pop_ok) begin
            n_rd_idx = (r_rd_idx == QIDX_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                                 : r_rd_idx + QIDX_BITS'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + QCNT_BITS'(1);
            2'b01:   n_count = r_count - QCNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_slot[r_wr_idx] <= i_item;
        end
    end

endmodule

### hdl/bf_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// bf_instruction_execute_unit
// Path: a transaction is registered in the front queue, executed, and registered
// again in the result queue. Throughput: one instruction per cycle unless the
// result queue is full, set by the execute step with neighbor cells held in
// registers around the one-write one-read memory.
// Reset: synchronous; clears queues, pointer, counter, status, offset to 300;
// cell memory reads as zero at and above a fill mark, with no clearing pass.
// ----------------------------------------------------------------------------
module bf_instruction_execute_unit
    import bfe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [OFFSET_BITS-1:0] i_cfg_wdata,
    input  logic                   push,
    input  t_cmd_item              i_cmd_item,
    output logic                   full,
    output logic                   empty,
    output t_result_item           o_result_item,
    input  logic                   pop
);

    logic         dec_valid;
    t_dec_item    dec_item;
    logic         dec_ready;
    logic         res_full;
    logic         res_push;
    t_result_item res_item;

    bfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_item      (i_cmd_item),
        .o_full      (full),
        .o_valid     (dec_valid),
        .o_item      (dec_item),
        .i_ready     (dec_ready)
    );

    bfe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (dec_valid),
        .i_item      (dec_item),
        .o_ready     (dec_ready),
        .i_res_ready (!res_full),
        .o_res_push  (res_push),
        .o_res_item  (res_item)
    );

    bfe_result_queue u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_item  (res_item),
        .o_full  (res_full),
        .o_empty (empty),
        .o_item  (o_result_item),
        .i_pop   (pop)
    );

endmodule

### hdl/bfe_checker.sv
// ----------------------------------------------------------------------------
// bfe_checker
// Port-level checks on the result side of the execute unit.
// ----------------------------------------------------------------------------
module bfe_checker
    import bfe_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         empty,
    input logic         pop,
    input t_result_item o_result_item
);

    logic        r_stopped;
    logic [11:0] r_stop_pc;
    t_status     r_stop_status;
    logic        take;

    assign take = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stopped     <= 1'b0;
            r_stop_pc     <= '0;
            r_stop_status <= ST_RUN;
        end else if (take && !r_stopped && (o_result_item.status != ST_RUN)) begin
            r_stopped     <= 1'b1;
            r_stop_pc     <= o_result_item.next_pc;
            r_stop_status <= o_result_item.status;
        end
    end

    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_stopped) |-> ((o_result_item.status == r_stop_status) &&
                                 (o_result_item.next_pc == r_stop_pc)))
        else $error("result changed after execution stopped");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !o_result_item.out_valid) |-> (o_result_item.out_value == 16'd0))
        else $error("value present without output flag");

    a_no_out_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && (o_result_item.status != ST_RUN)) |-> !o_result_item.out_valid)
        else $error("output emitted with non-running status");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result_item)))
        else $error("waiting result transaction not held");

endmodule

bind bf_instruction_execute_unit bfe_checker u_checker (.*);
